// File: rtl/bce_pkg.sv
// Shared types, constants and helpers of the bucket clock evictor.
package bce_pkg;

    localparam int MAX_BUCKET_BITS = 10;
    localparam int NBUCKETS        = 1 << MAX_BUCKET_BITS;
    localparam int CANDIDATES      = 4;
    localparam int CAND_IDX_W      = $clog2(CANDIDATES);
    localparam int CAND_CNT_W      = $clog2(CANDIDATES + 1);
    localparam int ITEMS_W         = 12;
    localparam int REMOVED_W       = 23;
    localparam int SAMPLE_W        = 16;

    localparam logic [ITEMS_W-1:0] ITEMS_MAX = '1;

    localparam logic [2:0] CMD_ACCESS = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_DELETE = 3'd2;
    localparam logic [2:0] CMD_EVICT  = 3'd3;
    localparam logic [2:0] CMD_AGE    = 3'd4;

    localparam logic REG_BUCKET_BITS  = 1'b0;
    localparam logic REG_SAMPLE_SHIFT = 1'b1;

    typedef enum logic [2:0] {
        OP_ACCESS,
        OP_INSERT,
        OP_DELETE,
        OP_EVICT,
        OP_AGE,
        OP_NOP
    } op_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_EX,
        ST_SC_RD,
        ST_SC_EV,
        ST_CL_RD,
        ST_CL_EV,
        ST_FIN,
        ST_AG_RD,
        ST_AG_EV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] hash_value;
        logic [19:0] item_bytes;
        logic [31:0] target_bytes;
    } in_t;

    typedef struct packed {
        logic [MAX_BUCKET_BITS-1:0] bucket_index;
        logic [31:0]                clock_value;
        logic [REMOVED_W-1:0]       items_removed;
        logic [31:0]                bytes_freed;
        logic [31:0]                age_decrement;
        logic                       aged;
    } out_t;

    typedef struct packed {
        logic [3:0] bucket_bits;
        logic [3:0] sample_shift;
    } cfg_t;

    typedef struct packed {
        op_t                        op;
        logic [MAX_BUCKET_BITS-1:0] bucket;
        logic [19:0]                item_bytes;
        logic [31:0]                target_bytes;
    } job_t;

    typedef struct packed {
        logic [31:0]        clock;
        logic [ITEMS_W-1:0] items;
        logic [31:0]        bytes;
    } entry_t;

    typedef struct packed {
        logic                       valid;
        logic [31:0]                clock;
        logic [MAX_BUCKET_BITS-1:0] index;
    } cand_t;

    function automatic logic [MAX_BUCKET_BITS-1:0] bucket_mask(input logic [3:0] bits);
        logic [3:0] eff;
        eff = bits;
        if (bits == 4'd0)
            eff = 4'd1;
        else if (32'(bits) > MAX_BUCKET_BITS)
            eff = 4'(MAX_BUCKET_BITS);
        return MAX_BUCKET_BITS'(({{MAX_BUCKET_BITS{1'b0}}, 1'b1} << eff) - 1'b1);
    endfunction

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// File: rtl/bucket_clock_evictor_unit.sv
// Top level of the bucket clock evictor: config registers, front end, queue, engine.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | in_data  (bce_pkg::in_t)
//  out     | output    | out_valid / out_stall| out_data (bce_pkg::out_t)
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// In the engine, access, insert and delete pass through a table read, a write and a result.
// Evict scans the buckets in use from the hand, then clears sorted candidates; age sweeps
// every bucket in use when an age decrement is pending, else it goes straight to the result.
// After reset a clearing pass writes all 1024 buckets with in_stall high.
// A full result register stalls the engine; the two-entry queue takes beats until it is full.
module bucket_clock_evictor_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  bce_pkg::in_t   in_data,
    output logic           in_stall,
    output logic           out_valid,
    output bce_pkg::out_t  out_data,
    input  logic           out_stall,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [3:0]     cfg_data
);

    bce_pkg::cfg_t cfg_reg, cfg_next;
    logic          hold;
    logic          q_full;
    logic          push;
    logic          pop;
    logic          q_valid;
    bce_pkg::job_t job_in;
    bce_pkg::job_t job_out;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                bce_pkg::REG_BUCKET_BITS:  cfg_next.bucket_bits  = cfg_data;
                bce_pkg::REG_SAMPLE_SHIFT: cfg_next.sample_shift = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bucket_bits  <= 4'(bce_pkg::MAX_BUCKET_BITS);
            cfg_reg.sample_shift <= 4'd0;
        end
        else
            cfg_reg <= cfg_next;
    end

    bce_front u_front (
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_stall (in_stall),
        .cfg      (cfg_reg),
        .hold     (hold),
        .q_full   (q_full),
        .push     (push),
        .job      (job_in)
    );

    bce_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_in),
        .full    (q_full),
        .pop     (pop),
        .valid   (q_valid),
        .job_out (job_out)
    );

    bce_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_job     (job_out),
        .pop       (pop),
        .clearing  (hold),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall)
    );

`ifndef SYNTH
    a_reset_holds_input: assert property (@(posedge clk) !rst_n |=> in_stall)
        else $error("input not held after reset");
    a_aged_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.aged |-> out_data.items_removed == '0 &&
        out_data.bytes_freed == '0 && out_data.age_decrement == '0)
        else $error("age result carries evict fields");
    a_bucket_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bucket_index != '0 |-> out_data.items_removed == '0 &&
        !out_data.aged)
        else $error("bucket result mixed with other fields");
`endif

endmodule

// File: rtl/bce_front.sv
// Front end: takes input beats, decodes the command and masks the bucket.
module bce_front (
    input  logic              in_valid,
    input  bce_pkg::in_t      in_data,
    output logic              in_stall,
    input  bce_pkg::cfg_t     cfg,
    input  logic              hold,
    input  logic              q_full,
    output logic              push,
    output bce_pkg::job_t     job
);

    logic [bce_pkg::MAX_BUCKET_BITS-1:0] mask;

    assign mask     = bce_pkg::bucket_mask(cfg.bucket_bits);
    assign in_stall = hold | q_full;
    assign push     = in_valid & ~in_stall;

    always_comb
    begin
        job.bucket       = in_data.hash_value[bce_pkg::MAX_BUCKET_BITS-1:0] & mask;
        job.item_bytes   = in_data.item_bytes;
        job.target_bytes = in_data.target_bytes;
        case (in_data.cmd)
            bce_pkg::CMD_ACCESS: job.op = bce_pkg::OP_ACCESS;
            bce_pkg::CMD_INSERT: job.op = bce_pkg::OP_INSERT;
            bce_pkg::CMD_DELETE: job.op = bce_pkg::OP_DELETE;
            bce_pkg::CMD_EVICT:  job.op = bce_pkg::OP_EVICT;
            bce_pkg::CMD_AGE:    job.op = bce_pkg::OP_AGE;
            default:             job.op = bce_pkg::OP_NOP;
        endcase
    end

endmodule

// File: rtl/bce_queue.sv
// Two-entry job queue between the front end and the engine.
module bce_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bce_pkg::job_t job_in,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output bce_pkg::job_t job_out
);

    bce_pkg::job_t ent_reg [2];
    logic          wp_reg, wp_next;
    logic          rp_reg, rp_next;
    logic [1:0]    cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign job_out = ent_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wp_reg] <= job_in;
    end

endmodule

// File: rtl/bce_back.sv
// Engine: bucket table, read-modify-write, eviction scan, ageing sweep, result register.
module bce_back (
    input  logic           clk,
    input  logic           rst_n,
    input  bce_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  bce_pkg::job_t  q_job,
    output logic           pop,
    output logic           clearing,
    output logic           out_valid,
    output bce_pkg::out_t  out_data,
    input  logic           out_stall
);

    localparam int BW = bce_pkg::MAX_BUCKET_BITS;
    localparam int CN = bce_pkg::CANDIDATES;

    bce_pkg::entry_t mem [bce_pkg::NBUCKETS];
    bce_pkg::entry_t rd_data_reg;

    bce_pkg::state_t state_reg, state_next;
    bce_pkg::job_t   job_reg, job_next;
    logic [BW-1:0]   idx_reg, idx_next;
    logic [BW-1:0]   hand_reg, hand_next;
    logic [BW-1:0]   n_reg, n_next;
    logic [bce_pkg::CAND_CNT_W-1:0] j_reg, j_next;
    bce_pkg::cand_t  cand_reg [CN];
    bce_pkg::cand_t  cand_next [CN];
    logic [bce_pkg::REMOVED_W-1:0] removed_reg, removed_next;
    logic [31:0]     freed_reg, freed_next;
    logic [31:0]     dec_reg, dec_next;
    logic [31:0]     pend_reg, pend_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [bce_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    bce_pkg::out_t   res_reg, res_next;
    logic            out_valid_reg, out_valid_next;
    bce_pkg::out_t   out_data_reg, out_data_next;

    logic            we;
    logic [BW-1:0]   wa;
    logic [BW-1:0]   ra;
    bce_pkg::entry_t wd;

    logic [BW-1:0]   mask;
    bce_pkg::entry_t cur;
    bce_pkg::entry_t ex_entry;
    logic [bce_pkg::SAMPLE_W-1:0] cnt1;
    logic            bump;
    logic            sc_skip;
    logic            sc_low;
    logic [31:0]     freed_add;
    logic [bce_pkg::REMOVED_W-1:0] removed_add;
    logic            hit;
    logic            cj_end;
    bce_pkg::cand_t  cj;
    bce_pkg::cand_t  ins_list [CN];
    logic [bce_pkg::CAND_CNT_W-1:0] ins_pos;
    logic            out_free;

    assign mask      = bce_pkg::bucket_mask(cfg.bucket_bits);
    assign cur       = rd_data_reg;
    assign out_free  = ~out_valid_reg | ~out_stall;
    assign clearing  = (state_reg == bce_pkg::ST_CLR);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cj        = cand_reg[j_reg[bce_pkg::CAND_IDX_W-1:0]];

    // Access, insert and delete update of the bucket read in the previous cycle.
    always_comb
    begin
        cnt1     = sample_reg + 1'b1;
        bump     = {1'b0, cnt1} >= (17'd1 << cfg.sample_shift);
        ex_entry = cur;
        case (job_reg.op)
            bce_pkg::OP_ACCESS, bce_pkg::OP_INSERT:
            begin
                if (bump && cur.clock != 32'hFFFF_FFFF)
                    ex_entry.clock = cur.clock + 32'd1;
                if (job_reg.op == bce_pkg::OP_INSERT)
                begin
                    if (cur.items != bce_pkg::ITEMS_MAX)
                        ex_entry.items = cur.items + 1'b1;
                    ex_entry.bytes = bce_pkg::sat_add32(cur.bytes, {12'd0, job_reg.item_bytes});
                end
            end
            bce_pkg::OP_DELETE:
            begin
                if (cur.items != '0)
                begin
                    ex_entry.items = cur.items - 1'b1;
                    ex_entry.bytes = (cur.bytes > {12'd0, job_reg.item_bytes})
                                   ? cur.bytes - {12'd0, job_reg.item_bytes} : 32'd0;
                    if (cur.items == bce_pkg::ITEMS_W'(1))
                    begin
                        ex_entry.clock = 32'd0;
                        ex_entry.bytes = 32'd0;
                    end
                end
            end
            default: ex_entry = cur;
        endcase
    end

    // Scan and clear decisions, sorted candidate insertion.
    always_comb
    begin
        sc_skip     = (cur.items == '0) ||
                      (cand_reg[CN-1].valid && cur.clock >= cand_reg[CN-1].clock);
        sc_low      = (cur.clock <= 32'd1);
        freed_add   = bce_pkg::sat_add32(freed_reg, cur.bytes);
        removed_add = removed_reg + bce_pkg::REMOVED_W'(cur.items);
        hit         = (freed_add >= job_reg.target_bytes);
        cj_end      = (32'(j_reg) == CN) || !cj.valid;
        ins_pos     = '0;
        for (int k = 0; k < CN; k++)
        begin
            if (cand_reg[k].valid && cand_reg[k].clock <= cur.clock)
                ins_pos = ins_pos + 1'b1;
        end
        for (int k = 0; k < CN; k++)
        begin
            if (32'(k) < 32'(ins_pos))
                ins_list[k] = cand_reg[k];
            else if (32'(k) == 32'(ins_pos))
                ins_list[k] = '{valid: 1'b1, clock: cur.clock, index: hand_reg};
            else
                ins_list[k] = cand_reg[(k > 0) ? k - 1 : 0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bce_pkg::ST_CLR:
                if (idx_reg == BW'(bce_pkg::NBUCKETS - 1))
                    state_next = bce_pkg::ST_IDLE;
            bce_pkg::ST_IDLE:
                if (q_valid)
                begin
                    case (q_job.op)
                        bce_pkg::OP_ACCESS,
                        bce_pkg::OP_INSERT,
                        bce_pkg::OP_DELETE: state_next = bce_pkg::ST_EX;
                        bce_pkg::OP_EVICT:  state_next = bce_pkg::ST_SC_RD;
                        bce_pkg::OP_AGE:    state_next = pend_valid_reg ? bce_pkg::ST_AG_RD
                                                                        : bce_pkg::ST_OUT;
                        default:            state_next = bce_pkg::ST_OUT;
                    endcase
                end
            bce_pkg::ST_EX:    state_next = bce_pkg::ST_OUT;
            bce_pkg::ST_SC_RD: state_next = bce_pkg::ST_SC_EV;
            bce_pkg::ST_SC_EV:
                if (!sc_skip && sc_low && hit)
                    state_next = bce_pkg::ST_FIN;
                else if (n_reg == mask)
                    state_next = bce_pkg::ST_CL_RD;
                else
                    state_next = bce_pkg::ST_SC_RD;
            bce_pkg::ST_CL_RD:
                state_next = cj_end ? bce_pkg::ST_FIN : bce_pkg::ST_CL_EV;
            bce_pkg::ST_CL_EV:
                state_next = (cur.items != '0 && hit) ? bce_pkg::ST_FIN : bce_pkg::ST_CL_RD;
            bce_pkg::ST_FIN:   state_next = bce_pkg::ST_OUT;
            bce_pkg::ST_AG_RD: state_next = bce_pkg::ST_AG_EV;
            bce_pkg::ST_AG_EV:
                state_next = (idx_reg == mask) ? bce_pkg::ST_OUT : bce_pkg::ST_AG_RD;
            bce_pkg::ST_OUT:
                if (out_free)
                    state_next = bce_pkg::ST_IDLE;
            default: state_next = bce_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        job_next        = job_reg;
        idx_next        = idx_reg;
        hand_next       = hand_reg;
        n_next          = n_reg;
        j_next          = j_reg;
        cand_next       = cand_reg;
        removed_next    = removed_reg;
        freed_next      = freed_reg;
        dec_next        = dec_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        sample_next     = sample_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg & out_stall;
        out_data_next   = out_data_reg;
        pop             = 1'b0;
        we              = 1'b0;
        wa              = job_reg.bucket;
        wd              = '0;
        ra              = job_reg.bucket;
        case (state_reg)
            bce_pkg::ST_CLR:
            begin
                we       = 1'b1;
                wa       = idx_reg;
                idx_next = idx_reg + 1'b1;
            end
            bce_pkg::ST_IDLE:
            begin
                ra = q_job.bucket;
                if (q_valid)
                begin
                    pop          = 1'b1;
                    job_next     = q_job;
                    idx_next     = '0;
                    // bring the hand into range only when a scan starts
                    if (q_job.op == bce_pkg::OP_EVICT)
                        hand_next = hand_reg & mask;
                    n_next       = '0;
                    j_next       = '0;
                    removed_next = '0;
                    freed_next   = '0;
                    dec_next     = '0;
                    res_next     = '0;
                    for (int k = 0; k < CN; k++)
                        cand_next[k].valid = 1'b0;
                end
            end
            bce_pkg::ST_EX:
            begin
                we = 1'b1;
                wd = ex_entry;
                if (job_reg.op == bce_pkg::OP_ACCESS || job_reg.op == bce_pkg::OP_INSERT)
                    sample_next = bump ? '0 : cnt1;
                res_next.bucket_index = job_reg.bucket;
                res_next.clock_value  = ex_entry.clock;
            end
            bce_pkg::ST_SC_RD:
                ra = hand_reg;
            bce_pkg::ST_SC_EV:
            begin
                ra = hand_reg;
                wa = hand_reg;
                if (!sc_skip)
                begin
                    if (sc_low)
                    begin
                        we           = 1'b1;
                        removed_next = removed_add;
                        freed_next   = freed_add;
                    end
                    else
                        cand_next = ins_list;
                end
                if (!(!sc_skip && sc_low && hit))
                begin
                    hand_next = (hand_reg + 1'b1) & mask;
                    n_next    = n_reg + 1'b1;
                end
            end
            bce_pkg::ST_CL_RD:
                ra = cj.index & mask;
            bce_pkg::ST_CL_EV:
            begin
                ra     = cj.index & mask;
                wa     = cj.index & mask;
                j_next = j_reg + 1'b1;
                if (cur.items != '0)
                begin
                    we           = 1'b1;
                    removed_next = removed_add;
                    freed_next   = freed_add;
                    dec_next     = cj.clock;
                end
            end
            bce_pkg::ST_FIN:
            begin
                res_next.items_removed = removed_reg;
                res_next.bytes_freed   = freed_reg;
                res_next.age_decrement = dec_reg;
                if (dec_reg > 32'd1)
                begin
                    pend_next       = dec_reg;
                    pend_valid_next = 1'b1;
                end
            end
            bce_pkg::ST_AG_RD:
                ra = idx_reg;
            bce_pkg::ST_AG_EV:
            begin
                ra       = idx_reg;
                we       = 1'b1;
                wa       = idx_reg;
                wd       = cur;
                wd.clock = (cur.clock > pend_reg) ? cur.clock - pend_reg : 32'd0;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == mask)
                begin
                    pend_valid_next = 1'b0;
                    res_next.aged   = 1'b1;
                end
            end
            bce_pkg::ST_OUT:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_data_reg <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bce_pkg::ST_CLR;
            idx_reg        <= '0;
            hand_reg       <= '0;
            sample_reg     <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < CN; k++)
                cand_reg[k] <= '1;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            hand_reg       <= hand_next;
            sample_reg     <= sample_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            cand_reg       <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        n_reg        <= n_next;
        j_reg        <= j_next;
        removed_reg  <= removed_next;
        freed_reg    <= freed_next;
        dec_reg      <= dec_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule
